// File: sv/lssl_pkg.sv
// ============================================================================
// lssl_pkg
// Shared types and constants for the lane striped storage latency model.
// ============================================================================
package lssl_pkg;

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [2:0] REG_RD_LAT = 3'd0;
    localparam logic [2:0] REG_WR_LAT = 3'd1;
    localparam logic [2:0] REG_RD_BW  = 3'd2;
    localparam logic [2:0] REG_WR_BW  = 3'd3;
    localparam logic [2:0] REG_LANES  = 3'd4;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam logic [31:0] DELAY_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] byte_count;
        logic [15:0] request_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] done_tag;
        logic        was_write;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] rd_lat;
        logic [15:0] wr_lat;
        logic [23:0] rd_bw;
        logic [23:0] wr_bw;
        logic [5:0]  lanes;
    } cfg_t;

endpackage

// File: sv/lssl_front.sv
// ============================================================================
// lssl_front
// Two-entry transaction queue; drops unused mode codes on entry.
// ============================================================================
module lssl_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  lssl_pkg::req_t  req,
    output logic            q_valid,
    input  logic            q_pop,
    output lssl_pkg::req_t  q_item
);

    lssl_pkg::req_t slot_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_ptr_reg;
    logic           wr_ptr_reg;
    logic           push;
    logic           pop;

    assign req_ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];
    assign pop       = q_pop && q_valid;
    assign push      = req_valid && req_ready && (req.mode != lssl_pkg::MODE_UNUSED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

// File: sv/lssl_div.sv
// ============================================================================
// lssl_div
// Restoring divider, one quotient bit per cycle: (bytes << 16) / bandwidth.
// ============================================================================
module lssl_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [39:0] quotient
);

    logic [39:0] q_reg;
    logic [23:0] rem_reg;
    logic [23:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [24:0] rem_sh;
    logic        ge;
    logic [24:0] rem_sub;

    assign rem_sh   = {rem_reg, q_reg[39]};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            q_reg    <= 40'd0;
            rem_reg  <= 24'd0;
            dvs_reg  <= 24'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                q_reg    <= dividend;
                rem_reg  <= 24'd0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? rem_sub[23:0] : rem_sh[23:0];
                q_reg   <= {q_reg[38:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd39)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: sv/lssl_back.sv
// ============================================================================
// lssl_back
// Request placement, delay computation, tick walk and lane dispatch.
// ============================================================================
module lssl_back
#(
    parameter int LANES      = 32,
    parameter int LANE_DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  lssl_pkg::cfg_t  cfg,
    input  logic            q_valid,
    output logic            q_pop,
    input  lssl_pkg::req_t  q_item,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output lssl_pkg::rsp_t  rsp
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW = $clog2(LANES + 1);
    localparam int DW = $clog2(LANE_DEPTH);
    localparam int FW = $clog2(LANE_DEPTH + 1);
    localparam int AW = $clog2(LANES * LANE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_CHECK, S_DIV, S_EMIT, S_TWALK, S_TDONE, S_DCHK, S_DLOAD
    } state_t;

    state_t             state_reg;
    state_t             ret_reg;
    lssl_pkg::req_t     item_reg;
    lssl_pkg::rsp_t     rsp_reg;
    logic               rsp_valid_reg;
    logic [CW-1:0]      nl_reg;
    logic [CW-1:0]      mod_reg;
    logic [CW-1:0]      eff;
    logic [LW-1:0]      lane_reg;
    logic [LW-1:0]      idx_reg;
    logic [FW-1:0]      fill_reg [LANES];
    logic [DW-1:0]      head_reg [LANES];
    logic [LANES-1:0]   fv_reg;
    logic [32:0]        ft_reg [LANES];
    logic [16:0]        fi_reg [LANES];
    logic [CW-1:0]      pend_reg;
    logic [48:0]        mem [LANES * LANE_DEPTH];
    logic [48:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [48:0]        wr_data;
    logic [LANES-1:0]   exp_mask;
    logic               later;
    logic               div_start;
    logic               div_done;
    logic [39:0]        quotient;
    logic               is_wr;
    logic [15:0]        lat;
    logic [23:0]        bw;
    logic [40:0]        sum;
    logic [31:0]        delay;
    logic [FW:0]        slot_sum;
    logic [DW-1:0]      slot;
    logic [7:0]         lanes8;
    logic               last_idx;

    lssl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({item_reg.byte_count, 16'd0}),
        .divisor  (bw),
        .done     (div_done),
        .quotient (quotient)
    );

    assign lanes8 = {2'd0, cfg.lanes};
    always_comb
    begin
        if (lanes8 == 8'd0)
        begin
            eff = CW'(1);
        end
        else if (lanes8 > 8'(LANES))
        begin
            eff = CW'(LANES);
        end
        else
        begin
            eff = CW'(lanes8);
        end
    end

    assign is_wr = (item_reg.mode == lssl_pkg::MODE_WRITE);
    assign lat   = is_wr ? cfg.wr_lat : cfg.rd_lat;
    assign bw    = is_wr ? cfg.wr_bw : cfg.rd_bw;
    assign sum   = 41'(lat) + 41'(quotient);
    assign delay = ((bw == 24'd0) || (sum[40:32] != 9'd0)) ? lssl_pkg::DELAY_MAX : sum[31:0];

    assign slot_sum = (FW+1)'(head_reg[lane_reg]) + (FW+1)'(fill_reg[lane_reg]);
    assign slot     = (slot_sum >= (FW+1)'(LANE_DEPTH))
                      ? DW'(slot_sum - (FW+1)'(LANE_DEPTH)) : DW'(slot_sum);

    assign wr_addr  = AW'(AW'(lane_reg) * AW'(LANE_DEPTH)) + AW'(slot);
    assign rd_addr  = AW'(AW'(idx_reg) * AW'(LANE_DEPTH)) + AW'(head_reg[idx_reg]);
    assign wr_en    = (state_reg == S_DIV) && div_done;
    assign wr_data  = {delay, item_reg.request_tag, is_wr};
    assign div_start = (state_reg == S_CHECK) && (fill_reg[lane_reg] != FW'(LANE_DEPTH));
    assign last_idx  = (idx_reg == LW'(LANES - 1));

    always_comb
    begin
        later = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            exp_mask[i] = fv_reg[i] && (ft_reg[i] <= 33'd1);
            if ((i > int'(idx_reg)) && exp_mask[i])
            begin
                later = 1'b1;
            end
        end
    end

    assign q_pop     = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            item_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            nl_reg        <= '0;
            mod_reg       <= '0;
            lane_reg      <= '0;
            idx_reg       <= '0;
            fv_reg        <= '0;
            pend_reg      <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
                ft_reg[i]   <= '0;
                fi_reg[i]   <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        idx_reg  <= '0;
                        mod_reg  <= nl_reg;
                        state_reg <= (q_item.mode == lssl_pkg::MODE_TICK) ? S_TWALK : S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (mod_reg >= eff)
                    begin
                        mod_reg <= mod_reg - eff;
                    end
                    else
                    begin
                        lane_reg  <= LW'(mod_reg);
                        nl_reg    <= mod_reg + CW'(1);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (fill_reg[lane_reg] == FW'(LANE_DEPTH))
                    begin
                        rsp_reg       <= '{lssl_pkg::KIND_REJECT, item_reg.request_tag,
                                           is_wr, 1'b1};
                        rsp_valid_reg <= 1'b1;
                        ret_reg       <= S_IDLE;
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        fill_reg[lane_reg] <= fill_reg[lane_reg] + FW'(1);
                        rsp_reg       <= '{lssl_pkg::KIND_ACCEPT, item_reg.request_tag,
                                           is_wr, 1'b1};
                        rsp_valid_reg <= 1'b1;
                        ret_reg       <= S_IDLE;
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        state_reg     <= ret_reg;
                    end
                end
                S_TWALK:
                begin
                    if (!last_idx)
                    begin
                        idx_reg <= idx_reg + LW'(1);
                    end
                    if (fv_reg[idx_reg])
                    begin
                        if (ft_reg[idx_reg] != 33'd0)
                        begin
                            ft_reg[idx_reg] <= ft_reg[idx_reg] - 33'd1;
                        end
                        if (exp_mask[idx_reg])
                        begin
                            fv_reg[idx_reg] <= 1'b0;
                            pend_reg        <= pend_reg - CW'(1);
                            rsp_reg       <= '{lssl_pkg::KIND_DONE, fi_reg[idx_reg][15:0],
                                               fi_reg[idx_reg][16], !later};
                            rsp_valid_reg <= 1'b1;
                            ret_reg       <= last_idx ? S_TDONE : S_TWALK;
                            state_reg     <= S_EMIT;
                        end
                        else if (last_idx)
                        begin
                            state_reg <= S_TDONE;
                        end
                    end
                    else if (last_idx)
                    begin
                        state_reg <= S_TDONE;
                    end
                end
                S_TDONE:
                begin
                    idx_reg   <= '0;
                    state_reg <= (pend_reg == '0) ? S_DCHK : S_IDLE;
                end
                S_DCHK:
                begin
                    if (fill_reg[idx_reg] != '0)
                    begin
                        state_reg <= S_DLOAD;
                    end
                    else if (last_idx)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + LW'(1);
                    end
                end
                S_DLOAD:
                begin
                    ft_reg[idx_reg]   <= {1'b0, rd_data_reg[48:17]} + 33'd1;
                    fi_reg[idx_reg]   <= {rd_data_reg[0], rd_data_reg[16:1]};
                    fv_reg[idx_reg]   <= 1'b1;
                    head_reg[idx_reg] <= (head_reg[idx_reg] == DW'(LANE_DEPTH - 1))
                                         ? '0 : head_reg[idx_reg] + DW'(1);
                    fill_reg[idx_reg] <= fill_reg[idx_reg] - FW'(1);
                    pend_reg          <= pend_reg + CW'(1);
                    if (last_idx)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + LW'(1);
                        state_reg <= S_DCHK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/lane_striped_ssd_latency_model.sv
// ============================================================================
// lane_striped_ssd_latency_model
// Storage latency emulator with per-lane FIFOs and a nanosecond tick.
// ============================================================================
// Request: a 40-step divider plus up to LANES+1 pointer steps;
// a rejected request skips the divider.
// Tick: a walk over the LANES timers, pausing at each completion handshake,
// then a dispatch pass over the lanes when nothing is in flight.
// One transaction is worked on at a time; two more can wait in the input queue.
// Reset: asynchronous; clears lanes, timers and registers to their defaults.
// ============================================================================
module lane_striped_ssd_latency_model
#(
    parameter int LANES      = 32,
    parameter int LANE_DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  lssl_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output lssl_pkg::rsp_t  rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [23:0]     cfg_data
);

    lssl_pkg::cfg_t cfg_reg;
    lssl_pkg::req_t q_item;
    logic           q_valid;
    logic           q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{16'd500, 16'd500, 24'd51200, 24'd51200, 6'd32};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lssl_pkg::REG_RD_LAT: cfg_reg.rd_lat <= cfg_data[15:0];
                lssl_pkg::REG_WR_LAT: cfg_reg.wr_lat <= cfg_data[15:0];
                lssl_pkg::REG_RD_BW:  cfg_reg.rd_bw  <= cfg_data;
                lssl_pkg::REG_WR_BW:  cfg_reg.wr_bw  <= cfg_data;
                lssl_pkg::REG_LANES:  cfg_reg.lanes  <= cfg_data[5:0];
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    lssl_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    lssl_back #(.LANES(LANES), .LANE_DEPTH(LANE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: sv/lssl_checker.sv
// ============================================================================
// lssl_checker
// Port-level checks on the response channel.
// ============================================================================
module lssl_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  lssl_pkg::rsp_t  rsp
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.kind == lssl_pkg::KIND_ACCEPT) ||
                      (rsp.kind == lssl_pkg::KIND_REJECT) ||
                      (rsp.kind == lssl_pkg::KIND_DONE))
        else $error("illegal response kind");

    a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind != lssl_pkg::KIND_DONE) |-> rsp.last)
        else $error("request response without last");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response during reset");

endmodule

bind lane_striped_ssd_latency_model lssl_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
